/* hdl/cht_pkg.sv */
`default_nettype none

package cht_pkg;

    localparam int CHT_SLOTS      = 1024;
    localparam int CHT_KICK_LIMIT = 2048;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 12;
    localparam int SEED_W   = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SEED_W-1:0] SEED_ONE_RESET = 7'd7;
    localparam logic [SEED_W-1:0] SEED_TWO_RESET = 7'd13;

    // offset added to the second table's slot
    localparam int HASH_TWO_OFFSET = 3;

    // register indexes (paddr word index)
    localparam logic REG_SEED_ONE = 1'b0;
    localparam logic REG_SEED_TWO = 1'b1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_UPDATED   = 3'd1,
        STATUS_REMOVED   = 3'd2,
        STATUS_NOT_FOUND = 3'd3,
        STATUS_FOUND     = 3'd4,
        STATUS_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [KEY_W-1:0] hash_product(input logic [KEY_W-1:0] key,
                                                      input logic [SEED_W-1:0] seed);
        logic [KEY_W-1:0] seed_ext;
        seed_ext = {{(KEY_W-SEED_W){1'b0}}, seed};
        return key * seed_ext;
    endfunction

endpackage

`default_nettype wire

/* hdl/cht_if.sv */
`default_nettype none

interface cht_cmd_if;
    import cht_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] key_in;
    logic signed [KEY_W-1:0] value_in;

    modport source (output valid, output command, output key_in, output value_in,
                    input ready);
    modport sink (input valid, input command, input key_in, input value_in,
                  output ready);
endinterface

interface cht_rsp_if;
    import cht_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] found_value;
    logic signed [KEY_W-1:0] homeless_key;
    logic signed [KEY_W-1:0] homeless_value;
    logic [COUNT_W-1:0]      occupancy;

    modport source (output valid, output status, output found_value,
                    output homeless_key, output homeless_value, output occupancy,
                    input ready);
    modport sink (input valid, input status, input found_value,
                  input homeless_key, input homeless_value, input occupancy,
                  output ready);
endinterface

`default_nettype wire

/* hdl/cht_ram.sv */
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/cuckoo_hash_table.sv */
// Lookup, remove, update and direct insert: the result is registered from ST_LOOKUP, or
// ST_RESP if rsp.ready holds it off; the next command is taken the cycle after that.
// Insert with evictions: a read state and a write state per displaced entry (one read and
// one write of a table memory each); the table memory port sets the pace.
// Reset: rst_n clears control state, then a pass over all SLOTS slots clears every valid
// bit in both tables, cmd.ready low meanwhile; seeds reset to 7 and 13, occupancy to zero.
`default_nettype none

module cuckoo_hash_table #(
    parameter int SLOTS      = cht_pkg::CHT_SLOTS,
    parameter int KICK_LIMIT = cht_pkg::CHT_KICK_LIMIT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cht_cmd_if.sink                         cmd,
    cht_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cht_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cht_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cht_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import cht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int RW = (KICK_LIMIT > 1) ? $clog2(KICK_LIMIT) : 1;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOOKUP = 8'b0000_0100,
        ST_READ1  = 8'b0000_1000,
        ST_CHECK1 = 8'b0001_0000,
        ST_READ2  = 8'b0010_0000,
        ST_CHECK2 = 8'b0100_0000,
        ST_RESP   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SEED_W-1:0]  seed_one_reg, seed_two_reg;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [KEY_W-1:0]   val_reg, val_next;
    logic [AW-1:0]      a_reg, a_next;
    logic [AW-1:0]      b_reg, b_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [KEY_W-1:0]   ck_reg, ck_next;
    logic [KEY_W-1:0]   cv_reg, cv_next;
    logic [RW-1:0]      round_reg, round_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // pending result while the output register is busy
    status_t            pend_status_reg;
    logic [KEY_W-1:0]   pend_found_reg, pend_hk_reg, pend_hv_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [KEY_W-1:0]   out_found_reg, out_hk_reg, out_hv_reg;
    logic [COUNT_W-1:0] out_occ_reg;

    logic               fin;
    status_t            fin_status;
    logic [KEY_W-1:0]   fin_found, fin_hk, fin_hv;
    logic               out_free, load_new, load_pend;

    logic               we1, we2, re1, re2;
    logic [AW-1:0]      waddr1, waddr2, raddr1, raddr2;
    entry_t             wdata1, wdata2, d1, d2;
    logic [ENTRY_W-1:0] rdata1, rdata2;

    logic [KEY_W-1:0]   hash_key, prod1, prod2;
    logic [AW-1:0]      slot1, slot2;
    logic               in_one, in_two, round_last;

    // ---------------- configuration port ----------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_one_reg <= SEED_ONE_RESET;
            seed_two_reg <= SEED_TWO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SEED_ONE: seed_one_reg <= pwdata[SEED_W-1:0];
                REG_SEED_TWO: seed_two_reg <= pwdata[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SEED_ONE: prdata = {{(APB_DATA_W-SEED_W){1'b0}}, seed_one_reg};
            REG_SEED_TWO: prdata = {{(APB_DATA_W-SEED_W){1'b0}}, seed_two_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------- table memories ----------------
    cht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table_one (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .re    (re1),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    cht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table_two (
        .clk   (clk),
        .we    (we2),
        .waddr (waddr2),
        .wdata (wdata2),
        .re    (re2),
        .raddr (raddr2),
        .rdata (rdata2)
    );

    assign d1 = entry_t'(rdata1);
    assign d2 = entry_t'(rdata2);

    // ---------------- hashing ----------------
    assign hash_key = (state_reg == ST_IDLE) ? cmd.key_in : ck_reg;
    assign prod1    = hash_product(hash_key, seed_one_reg);
    assign prod2    = hash_product(hash_key, seed_two_reg);
    assign slot1    = prod1[AW-1:0];
    assign slot2    = prod2[AW-1:0] + AW'(HASH_TWO_OFFSET);

    assign in_one     = d1.valid && (d1.key == key_reg);
    assign in_two     = d2.valid && (d2.key == key_reg);
    assign round_last = (round_reg == RW'(KICK_LIMIT - 1));

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        ck_next    = ck_reg;
        cv_next    = cv_reg;
        round_next = round_reg;
        count_next = count_reg;

        we1    = 1'b0;
        we2    = 1'b0;
        waddr1 = a_reg;
        waddr2 = b_reg;
        wdata1 = '0;
        wdata2 = '0;
        re1    = 1'b0;
        re2    = 1'b0;
        raddr1 = slot1;
        raddr2 = slot2;

        fin        = 1'b0;
        fin_status = STATUS_NOT_FOUND;
        fin_found  = '0;
        fin_hk     = '0;
        fin_hv     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we1    = 1'b1;
                we2    = 1'b1;
                waddr1 = clr_reg;
                waddr2 = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // read both home slots speculatively; take them if a transaction lands
                re1 = 1'b1;
                re2 = 1'b1;
                if (cmd.valid)
                begin
                    cmd_next   = cmd.command;
                    key_next   = cmd.key_in;
                    val_next   = cmd.value_in;
                    a_next     = slot1;
                    b_next     = slot2;
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                fin = 1'b1;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (in_one)
                        begin
                            we1        = 1'b1;
                            wdata1     = '{valid: 1'b1, key: key_reg, value: val_reg};
                            fin_status = STATUS_UPDATED;
                        end
                        else if (in_two)
                        begin
                            we2        = 1'b1;
                            wdata2     = '{valid: 1'b1, key: key_reg, value: val_reg};
                            fin_status = STATUS_UPDATED;
                        end
                        else
                        begin
                            we1    = 1'b1;
                            wdata1 = '{valid: 1'b1, key: key_reg, value: val_reg};
                            if (!d1.valid)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                                fin_status = STATUS_INSERTED;
                            end
                            else
                            begin
                                // evict the resident of table one, push it to table two
                                fin        = 1'b0;
                                ck_next    = d1.key;
                                cv_next    = d1.value;
                                round_next = '0;
                                state_next = ST_READ2;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (in_one)
                        begin
                            we1        = 1'b1;
                            wdata1     = '{valid: 1'b0, key: d1.key, value: d1.value};
                            count_next = count_reg - COUNT_W'(1);
                            fin_status = STATUS_REMOVED;
                        end
                        else if (in_two)
                        begin
                            we2        = 1'b1;
                            wdata2     = '{valid: 1'b0, key: d2.key, value: d2.value};
                            count_next = count_reg - COUNT_W'(1);
                            fin_status = STATUS_REMOVED;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (in_one)
                        begin
                            fin_found  = d1.value;
                            fin_status = STATUS_FOUND;
                        end
                        else if (in_two)
                        begin
                            fin_found  = d2.value;
                            fin_status = STATUS_FOUND;
                        end
                    end
                    default: ;
                endcase
            end

            ST_READ1:
            begin
                re1        = 1'b1;
                idx_next   = slot1;
                state_next = ST_CHECK1;
            end

            ST_CHECK1:
            begin
                we1    = 1'b1;
                waddr1 = idx_reg;
                wdata1 = '{valid: 1'b1, key: ck_reg, value: cv_reg};
                if (!d1.valid)
                begin
                    fin        = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    fin_status = STATUS_INSERTED;
                end
                else
                begin
                    ck_next    = d1.key;
                    cv_next    = d1.value;
                    state_next = ST_READ2;
                end
            end

            ST_READ2:
            begin
                re2        = 1'b1;
                idx_next   = slot2;
                state_next = ST_CHECK2;
            end

            ST_CHECK2:
            begin
                we2    = 1'b1;
                waddr2 = idx_reg;
                wdata2 = '{valid: 1'b1, key: ck_reg, value: cv_reg};
                if (!d2.valid)
                begin
                    fin        = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    fin_status = STATUS_INSERTED;
                end
                else if (round_last)
                begin
                    // out of rounds: report the pair just evicted
                    fin        = 1'b1;
                    fin_status = STATUS_FULL;
                    fin_hk     = d2.key;
                    fin_hv     = d2.value;
                end
                else
                begin
                    ck_next    = d2.key;
                    cv_next    = d2.value;
                    round_next = round_reg + RW'(1);
                    state_next = ST_READ1;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? ST_IDLE : ST_RESP;
        end
    end

    assign load_new  = fin && out_free;
    assign load_pend = (state_reg == ST_RESP) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            round_reg <= round_next;
            if (load_new || load_pend)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        val_reg <= val_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        idx_reg <= idx_next;
        ck_reg  <= ck_next;
        cv_reg  <= cv_next;
        if (fin)
        begin
            pend_status_reg <= fin_status;
            pend_found_reg  <= fin_found;
            pend_hk_reg     <= fin_hk;
            pend_hv_reg     <= fin_hv;
        end
        if (load_new)
        begin
            out_status_reg <= fin_status;
            out_found_reg  <= fin_found;
            out_hk_reg     <= fin_hk;
            out_hv_reg     <= fin_hv;
            out_occ_reg    <= count_next;
        end
        else if (load_pend)
        begin
            out_status_reg <= pend_status_reg;
            out_found_reg  <= pend_found_reg;
            out_hk_reg     <= pend_hk_reg;
            out_hv_reg     <= pend_hv_reg;
            out_occ_reg    <= count_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_value    = out_found_reg;
    assign rsp.homeless_key   = out_hk_reg;
    assign rsp.homeless_value = out_hv_reg;
    assign rsp.occupancy      = out_occ_reg;

endmodule

`default_nettype wire

/* hdl/cht_checker.sv */
`default_nettype none

module cht_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_ready,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic [cht_pkg::STATUS_W-1:0]   rsp_status,
    input  logic [cht_pkg::KEY_W-1:0]      rsp_found_value,
    input  logic [cht_pkg::KEY_W-1:0]      rsp_homeless_key,
    input  logic [cht_pkg::KEY_W-1:0]      rsp_homeless_value
);
    import cht_pkg::*;

    // one command at a time: after a transaction the input side closes
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while previous command in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transaction");

    a_homeless_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STATUS_FULL)
            |-> (rsp_homeless_key == '0) && (rsp_homeless_value == '0))
        else $error("homeless pair reported without table full");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STATUS_FOUND) |-> (rsp_found_value == '0))
        else $error("found value nonzero without found status");

endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_found_value    (rsp.found_value),
    .rsp_homeless_key   (rsp.homeless_key),
    .rsp_homeless_value (rsp.homeless_value)
);

`default_nettype wire

/* tb/sv/cuckoo_hash_table_checker.sv */
module cuckoo_hash_table_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    cht_cmd_if                             cmd,
    cht_rsp_if                             rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [cht_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cht_pkg::APB_DATA_W-1:0] pwdata,
    output int                             failures,
    output int                             pending,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import cht_pkg::*;

    localparam int SLOT_BITS = $clog2(CHT_SLOTS);

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   found_value;
        logic [KEY_W-1:0]   homeless_key;
        logic [KEY_W-1:0]   homeless_value;
        logic [COUNT_W-1:0] occupancy;
    } outcome_t;

    logic [KEY_W-1:0]   left_key [CHT_SLOTS];
    logic [KEY_W-1:0]   left_val [CHT_SLOTS];
    bit                 left_live [CHT_SLOTS];
    logic [KEY_W-1:0]   right_key [CHT_SLOTS];
    logic [KEY_W-1:0]   right_val [CHT_SLOTS];
    bit                 right_live [CHT_SLOTS];
    logic [SEED_W-1:0]  mult_one;
    logic [SEED_W-1:0]  mult_two;
    logic [COUNT_W-1:0] live_count;
    outcome_t           pending_outcomes[$];

    function automatic slot_t left_home(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] prod;
        prod = key * KEY_W'(mult_one);
        return prod[SLOT_BITS-1:0];
    endfunction

    function automatic slot_t right_home(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] prod;
        slot_t            h;
        prod = key * KEY_W'(mult_two);
        h = prod[SLOT_BITS-1:0];
        h = h + slot_t'(HASH_TWO_OFFSET);
        return h;
    endfunction

    // Run one command against the shadow tables and return its response
    function automatic outcome_t apply_command(input logic [CMD_W-1:0] op,
                                               input logic [KEY_W-1:0] key,
                                               input logic [KEY_W-1:0] val);
        outcome_t         res;
        slot_t            a;
        slot_t            b;
        slot_t            i;
        logic             hit_left;
        logic             hit_right;
        logic             placed;
        logic [KEY_W-1:0] carry_key;
        logic [KEY_W-1:0] carry_val;
        logic [KEY_W-1:0] swap;
        int               round;
        res = '0;
        res.status = STATUS_NOT_FOUND;
        a = left_home(key);
        b = right_home(key);
        hit_left = left_live[a] && left_key[a] == key;
        hit_right = right_live[b] && right_key[b] == key;
        case (op)
            CMD_INSERT:
            begin
                if (hit_left)
                begin
                    left_val[a] = val;
                    res.status = STATUS_UPDATED;
                end
                else if (hit_right)
                begin
                    right_val[b] = val;
                    res.status = STATUS_UPDATED;
                end
                else
                begin
                    carry_key = key;
                    carry_val = val;
                    placed = 1'b0;
                    for (round = 0; round < CHT_KICK_LIMIT && !placed; round++)
                    begin
                        i = left_home(carry_key);
                        if (!left_live[i])
                        begin
                            left_key[i] = carry_key;
                            left_val[i] = carry_val;
                            left_live[i] = 1'b1;
                            placed = 1'b1;
                        end
                        else
                        begin
                            // evict the resident and push it to the other table
                            swap = left_key[i];
                            left_key[i] = carry_key;
                            carry_key = swap;
                            swap = left_val[i];
                            left_val[i] = carry_val;
                            carry_val = swap;
                            i = right_home(carry_key);
                            if (!right_live[i])
                            begin
                                right_key[i] = carry_key;
                                right_val[i] = carry_val;
                                right_live[i] = 1'b1;
                                placed = 1'b1;
                            end
                            else
                            begin
                                swap = right_key[i];
                                right_key[i] = carry_key;
                                carry_key = swap;
                                swap = right_val[i];
                                right_val[i] = carry_val;
                                carry_val = swap;
                            end
                        end
                    end
                    if (placed)
                    begin
                        live_count = live_count + COUNT_W'(1);
                        res.status = STATUS_INSERTED;
                    end
                    else
                    begin
                        res.status = STATUS_FULL;
                        res.homeless_key = carry_key;
                        res.homeless_value = carry_val;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (hit_left)
                begin
                    left_live[a] = 1'b0;
                    live_count = live_count - COUNT_W'(1);
                    res.status = STATUS_REMOVED;
                end
                else if (hit_right)
                begin
                    right_live[b] = 1'b0;
                    live_count = live_count - COUNT_W'(1);
                    res.status = STATUS_REMOVED;
                end
            end
            CMD_FIND:
            begin
                if (hit_left)
                begin
                    res.found_value = left_val[a];
                    res.status = STATUS_FOUND;
                end
                else if (hit_right)
                begin
                    res.found_value = right_val[b];
                    res.status = STATUS_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        res.occupancy = live_count;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    initial
    begin
        failures = 0;
        pending = 0;
        checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int j = 0; j < CHT_SLOTS; j++)
            begin
                left_live[j] = 1'b0;
                right_live[j] = 1'b0;
            end
            mult_one = SEED_ONE_RESET;
            mult_two = SEED_TWO_RESET;
            live_count = '0;
            pending_outcomes.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[APB_ADDR_W-1:2] == REG_SEED_ONE)
                    mult_one = pwdata[SEED_W-1:0];
                else
                    mult_two = pwdata[SEED_W-1:0];
            end
            if (rsp.valid && rsp.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("response transaction with no command outstanding");
                    failures++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("found_value", want.found_value, rsp.found_value);
                    check_field("homeless_key", want.homeless_key, rsp.homeless_key);
                    check_field("homeless_value", want.homeless_value, rsp.homeless_value);
                    check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
                    checked++;
                end
            end
            if (cmd.valid && cmd.ready)
                pending_outcomes.push_back(apply_command(cmd.command, cmd.key_in,
                                                         cmd.value_in));
            pending = pending_outcomes.size();
        end
    end

endmodule

/* tb/sv/cuckoo_hash_table_test.sv */
module cuckoo_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cht_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int KEY_POOL = 48;
    localparam int RSP_HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int  failures;
    int  pending;
    int  checked;
    int  sent;
    int  reg_writes;
    int  rsp_gap;
    bit  hold_req;
    bit  steady;

    logic [KEY_W-1:0] key_pool [KEY_POOL];

    cht_cmd_if cmd_ch ();
    cht_rsp_if rsp_ch ();

    cuckoo_hash_table uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cuckoo_hash_table_checker watch (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .failures (failures),
        .pending  (pending),
        .checked  (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Response side: random back-pressure, plus one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        rsp_gap = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b1;
            end
            else if (rsp_gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_gap--;
            end
            else
            begin
                rsp_gap = pick_gap();
                rsp_ch.ready <= (rsp_gap == 0);
            end
        end
    end

    task automatic send(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key,
                        input logic [KEY_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.key_in <= key;
        cmd_ch.value_in <= val;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Drop valid and hold until every response is back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [SEED_W-1:0] seed);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[SEED_W-1:0] = seed;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // leave the bus idle before the next access
        @(negedge clk);
        reg_writes++;
    endtask

    task automatic set_seeds(input logic [SEED_W-1:0] one, input logic [SEED_W-1:0] two);
        drain();
        write_reg(REG_SEED_ONE, one);
        write_reg(REG_SEED_TWO, two);
    endtask

    task automatic random_phase(input int count);
        int               r;
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] val;
        for (int n = 0; n < count; n++)
        begin
            if (!steady && $urandom_range(0, 39) == 0)
                drain();
            r = $urandom_range(0, 99);
            if (r < 50)
                op = CMD_INSERT;
            else if (r < 70)
                op = CMD_REMOVE;
            else if (r < 96)
                op = CMD_FIND;
            else
                op = CMD_UNUSED;
            // mostly reuse a small key set so updates, finds and removes hit
            if ($urandom_range(0, 4) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            val = $urandom;
            if ($urandom_range(0, 9) == 0)
                val = key_pool[$urandom_range(0, 3)];
            send(op, key, val);
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0]  pair_a;
        logic [KEY_W-1:0]  pair_b;
        logic [SEED_W-1:0] odd_one;
        logic [SEED_W-1:0] odd_two;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_INSERT;
        cmd_ch.key_in = '0;
        cmd_ch.value_in = '0;
        hold_req = 1'b0;
        steady = 1'b0;
        sent = 0;
        reg_writes = 0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h7fff_ffff;
        key_pool[3] = 32'hffff_ffff;
        for (int j = 4; j < KEY_POOL; j++)
            key_pool[j] = $urandom;
        pair_a = 32'h0000_0011;
        pair_b = 32'h0000_0022;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Leave a key in both tables: park it in table two, then re-insert it
        // into table one under a different second hash
        write_reg(REG_SEED_ONE, '0);
        send(CMD_INSERT, pair_a, 32'h0000_0001);
        send(CMD_INSERT, pair_b, 32'h0000_0002);
        send(CMD_REMOVE, pair_b, '0);
        drain();
        write_reg(REG_SEED_TWO, 7'h7f);
        send(CMD_INSERT, pair_a, 32'h0000_0003);
        drain();
        write_reg(REG_SEED_TWO, SEED_TWO_RESET);
        send(CMD_REMOVE, pair_a, '0);
        send(CMD_FIND, pair_a, '0);

        // Both hashes constant: the third distinct key overflows
        drain();
        write_reg(REG_SEED_TWO, '0);
        for (int j = 0; j < 4; j++)
            send(CMD_INSERT, 32'h1000_0000 + j, $urandom);

        set_seeds(SEED_ONE_RESET, SEED_TWO_RESET);
        send(CMD_INSERT, 32'h0000_0000, 32'h7fff_ffff);
        send(CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
        send(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        send(CMD_FIND, 32'h8000_0000, 32'hffff_ffff);
        send(CMD_FIND, 32'h1234_5678, '0);
        send(CMD_REMOVE, 32'h7fff_ffff, '0);
        send(CMD_REMOVE, 32'h7fff_ffff, '0);
        send(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        // same first slot as key zero: pushes it into table two
        send(CMD_INSERT, 32'h0000_0400, 32'h5a5a_5a5a);
        send(CMD_FIND, 32'h0000_0000, '0);
        send(CMD_INSERT, 32'h0000_0000, 32'h0000_0001);

        set_seeds(SEED_ONE_RESET, SEED_TWO_RESET);
        random_phase(90);
        set_seeds(7'd103, 7'd109);
        hold_req = 1'b1;
        random_phase(90);
        set_seeds(7'd127, 7'd1);
        random_phase(80);
        set_seeds(7'd64, 7'd127);
        random_phase(80);
        odd_one = SEED_W'($urandom);
        odd_two = SEED_W'($urandom);
        odd_one[0] = 1'b1;
        odd_two[0] = 1'b1;
        set_seeds(odd_one, odd_two);
        random_phase(80);
        set_seeds(SEED_ONE_RESET, SEED_TWO_RESET);
        steady = 1'b1;
        random_phase(80);
        steady = 1'b0;

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d commands across %0d register writes; %0d responses compared.",
                 sent, reg_writes, checked);
        $display("Covered updates, evictions, overflow, dual-copy remove and back-pressure.");
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
